[hw/rtl/pwom_pkg.sv]
`timescale 1ns / 1ps
// Package for the wavetable oscillator mixer: types, codes, step tables and
// the quarter-wave lookup. Depends on nothing; the module files import it.
package pwom_pkg;

	localparam int VOICES   = 4;
	localparam int VOICE_AW = 2;

	localparam logic [7:0] NOTE_PAUSE = 8'h80;
	localparam logic [7:0] WAVE_MID   = 8'd128;

	typedef enum logic [1:0] {
		ACT_SET_NOTE = 2'd0,
		ACT_SAMPLE   = 2'd1,
		ACT_CLEAR    = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0] note;
		logic [9:0] idx;
		logic [7:0] frac;
	} voice_t;

	typedef struct packed {
		logic                rd_en;
		logic [VOICE_AW-1:0] rd_addr;
		logic                wr_note_en;
		logic                wr_phase_en;
		logic [VOICE_AW-1:0] wr_addr;
		logic                clr;
	} ram_ctl_t;

	localparam logic [10:0] STEP_BASE [0:127] = '{
		11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd1,
		11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1,
		11'd1, 11'd1, 11'd1, 11'd2, 11'd2, 11'd2, 11'd2, 11'd2,
		11'd2, 11'd2, 11'd3, 11'd3, 11'd3, 11'd3, 11'd3, 11'd4,
		11'd4, 11'd4, 11'd4, 11'd5, 11'd5, 11'd5, 11'd6, 11'd6,
		11'd6, 11'd7, 11'd7, 11'd8, 11'd8, 11'd9, 11'd9, 11'd10,
		11'd10, 11'd11, 11'd12, 11'd12, 11'd13, 11'd14, 11'd15, 11'd16,
		11'd17, 11'd18, 11'd19, 11'd20, 11'd21, 11'd22, 11'd24, 11'd25,
		11'd27, 11'd28, 11'd30, 11'd32, 11'd34, 11'd36, 11'd38, 11'd40,
		11'd42, 11'd45, 11'd48, 11'd50, 11'd54, 11'd57, 11'd60, 11'd64,
		11'd68, 11'd72, 11'd76, 11'd80, 11'd85, 11'd90, 11'd96, 11'd101,
		11'd108, 11'd114, 11'd121, 11'd128, 11'd136, 11'd144, 11'd152, 11'd161,
		11'd171, 11'd181, 11'd192, 11'd203, 11'd216, 11'd228, 11'd242, 11'd256,
		11'd272, 11'd288, 11'd305, 11'd323, 11'd342, 11'd363, 11'd384, 11'd407,
		11'd432, 11'd457, 11'd484, 11'd513, 11'd544, 11'd576, 11'd611, 11'd647,
		11'd685, 11'd726, 11'd769, 11'd815, 11'd864, 11'd915, 11'd969, 11'd1027
	};

	localparam logic [7:0] STEP_FRAC [0:127] = '{
		8'd171, 8'd182, 8'd192, 8'd204, 8'd216, 8'd229, 8'd242, 8'd1,
		8'd16, 8'd32, 8'd50, 8'd68, 8'd87, 8'd107, 8'd129, 8'd152,
		8'd176, 8'd202, 8'd229, 8'd2, 8'd32, 8'd65, 8'd99, 8'd135,
		8'd174, 8'd215, 8'd2, 8'd48, 8'd96, 8'd147, 8'd202, 8'd4,
		8'd65, 8'd129, 8'd198, 8'd15, 8'd92, 8'd173, 8'd4, 8'd95,
		8'd192, 8'd39, 8'd148, 8'd7, 8'd129, 8'd3, 8'd140, 8'd29,
		8'd183, 8'd90, 8'd7, 8'd190, 8'd128, 8'd78, 8'd40, 8'd14,
		8'd3, 8'd6, 8'd24, 8'd59, 8'd111, 8'd181, 8'd15, 8'd125,
		8'd1, 8'd156, 8'd79, 8'd29, 8'd6, 8'd11, 8'd48, 8'd117,
		8'd221, 8'd106, 8'd29, 8'd250, 8'd2, 8'd56, 8'd159, 8'd57,
		8'd11, 8'd23, 8'd96, 8'd235, 8'd187, 8'd212, 8'd58, 8'd243,
		8'd3, 8'd111, 8'd61, 8'd115, 8'd22, 8'd46, 8'd193, 8'd214,
		8'd117, 8'd168, 8'd117, 8'd230, 8'd6, 8'd223, 8'd123, 8'd230,
		8'd45, 8'd92, 8'd129, 8'd172, 8'd235, 8'd79, 8'd234, 8'd205,
		8'd13, 8'd190, 8'd246, 8'd204, 8'd89, 8'd184, 8'd3, 8'd88,
		8'd214, 8'd158, 8'd211, 8'd154, 8'd25, 8'd123, 8'd235, 8'd152
	};

	// The quarter-wave table is a linear ramp.
	function automatic logic [6:0] quarter_wave(input logic [7:0] pos);
		return pos[7:1];
	endfunction

	function automatic logic [7:0] wave_value(input logic [9:0] idx);
		logic [6:0] r;
		r = idx[8] ? quarter_wave(~idx[7:0]) : quarter_wave(idx[7:0]);
		return idx[9] ? (WAVE_MID - {1'b0, r}) : (WAVE_MID + {1'b0, r});
	endfunction

endpackage

[hw/rtl/pwom_ifs.sv]
`timescale 1ns / 1ps
// Handshake channels of the oscillator mixer: the command channel and the
// sample channel, each with valid, ready and payload. No dependencies.
interface pwom_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] voice;
	logic [7:0] note;

	modport source (output valid, action, voice, note, input ready);
	modport sink (input valid, action, voice, note, output ready);
endinterface

interface pwom_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

[hw/rtl/pwom_voice_ram.sv]
`timescale 1ns / 1ps
// Voice state memory: note, phase index and fraction per voice, registered
// read, separate note and phase writes, valid bits for reset and clear.
// Depends on pwom_pkg.
module pwom_voice_ram (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pwom_pkg::ram_ctl_t                 ctl,
	input  logic [7:0]                         wr_note,
	input  logic [9:0]                         wr_idx,
	input  logic [7:0]                         wr_frac,
	output pwom_pkg::voice_t                   rd_data
);
	import pwom_pkg::*;

	logic [7:0]        note_mem [VOICES];
	logic [17:0]       phase_mem [VOICES];
	logic [VOICES-1:0] note_vld_q;
	logic [VOICES-1:0] phase_vld_q;
	voice_t            rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_note_en) begin
			note_mem[ctl.wr_addr] <= wr_note;
		end
		if (ctl.wr_phase_en) begin
			phase_mem[ctl.wr_addr] <= {wr_idx, wr_frac};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_vld_q  <= '0;
			phase_vld_q <= '0;
		end else if (ctl.clr) begin
			note_vld_q  <= '0;
			phase_vld_q <= '0;
		end else begin
			if (ctl.wr_note_en) begin
				note_vld_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.wr_phase_en) begin
				phase_vld_q[ctl.wr_addr] <= 1'b1;
			end
		end
	end

	// An entry not written since reset or clear reads as a paused voice at phase zero.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q.note <= note_vld_q[ctl.rd_addr] ? note_mem[ctl.rd_addr] : NOTE_PAUSE;
			{rd_q.idx, rd_q.frac} <= phase_vld_q[ctl.rd_addr] ? phase_mem[ctl.rd_addr] : '0;
		end
	end

	assign rd_data = rd_q;

endmodule

[hw/rtl/pwom_voice_step.sv]
`timescale 1ns / 1ps
// Per-voice datapath: wave value from the current phase and the advanced
// phase from the note's step. Depends on pwom_pkg.
module pwom_voice_step (
	input  pwom_pkg::voice_t cur,
	output logic             paused,
	output logic [7:0]       value,
	output logic [9:0]       nxt_idx,
	output logic [7:0]       nxt_frac
);
	import pwom_pkg::*;

	logic [8:0]  frac_sum;
	logic [10:0] base;

	assign paused   = cur.note[7];
	assign base     = STEP_BASE[cur.note[6:0]];
	assign frac_sum = {1'b0, cur.frac} + {1'b0, STEP_FRAC[cur.note[6:0]]};
	assign nxt_frac = frac_sum[7:0];
	assign nxt_idx  = cur.idx + base[9:0] + {9'd0, frac_sum[8]};
	assign value    = paused ? WAVE_MID : wave_value(cur.idx);

endmodule

[hw/rtl/polyphonic_wavetable_oscillator_mixer.sv]
`timescale 1ns / 1ps
// Four-voice wavetable oscillator mixer. Set-note, clear and unused commands finish in idle.
// A sample command holds the command channel through the accept state, a read phase that
// takes the clipped voice count, one voice per cycle, from the voice memory read port and
// then drains its read stage, a divide state and an output handoff state. The word is valid
// once the handoff state loads it; the handoff waits while an earlier word is still held.
// The output register lets the next command be taken while a sample still waits.
// Depends on pwom_pkg, pwom_ifs, pwom_voice_ram and pwom_voice_step.
module polyphonic_wavetable_oscillator_mixer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_wdata,
	pwom_in_if.sink           cmd,
	pwom_out_if.source        mix
);
	import pwom_pkg::*;

	state_t              state_q, state_d;
	ram_ctl_t            ram_ctl;
	voice_t              rd_data;
	logic                paused;
	logic [7:0]          value;
	logic [9:0]          nxt_idx;
	logic [7:0]          nxt_frac;
	logic [2:0]          vc_q;
	logic [2:0]          cnt_q;
	logic [2:0]          cnt_clip;
	logic [2:0]          rd_cnt_q;
	logic                vld_s1;
	logic [VOICE_AW-1:0] idx_s1;
	logic [9:0]          sum_q;
	logic [7:0]          res_q;
	logic [7:0]          res_d;
	logic [19:0]         third_prod;
	logic                mix_vld_q;
	logic [7:0]          sample_q;
	logic                cmd_rdy;
	logic                start;
	logic                load;

	pwom_voice_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ram_ctl),
		.wr_note (cmd.note),
		.wr_idx  (nxt_idx),
		.wr_frac (nxt_frac),
		.rd_data (rd_data)
	);

	pwom_voice_step u_step (
		.cur      (rd_data),
		.paused   (paused),
		.value    (value),
		.nxt_idx  (nxt_idx),
		.nxt_frac (nxt_frac)
	);

	assign cnt_clip   = (vc_q > 3'(VOICES)) ? 3'(VOICES) : vc_q;
	assign third_prod = 20'(sum_q) * 20'd683;

	always_comb begin
		unique case (cnt_q)
			3'd1:    res_d = sum_q[7:0];
			3'd2:    res_d = sum_q[8:1];
			3'd3:    res_d = third_prod[18:11];
			3'd4:    res_d = sum_q[9:2];
			default: res_d = 8'd0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		ram_ctl = '0;
		cmd_rdy = 1'b0;
		start   = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_rdy         = 1'b1;
				ram_ctl.wr_addr = cmd.voice;
				if (cmd.valid) begin
					unique case (action_t'(cmd.action))
						ACT_SET_NOTE: begin
							ram_ctl.wr_note_en = ({1'b0, cmd.voice} < 3'(VOICES));
						end
						ACT_CLEAR: begin
							ram_ctl.clr = 1'b1;
						end
						ACT_SAMPLE: begin
							start   = 1'b1;
							state_d = ST_RUN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RUN: begin
				ram_ctl.rd_en       = (rd_cnt_q < cnt_q);
				ram_ctl.rd_addr     = rd_cnt_q[VOICE_AW-1:0];
				ram_ctl.wr_addr     = idx_s1;
				ram_ctl.wr_phase_en = vld_s1 && !paused;
				if ((rd_cnt_q == cnt_q) && !vld_s1) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!mix_vld_q || mix.ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vc_q      <= 3'd0;
			cnt_q     <= 3'd0;
			rd_cnt_q  <= 3'd0;
			vld_s1    <= 1'b0;
			mix_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= ram_ctl.rd_en;
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			if (start) begin
				cnt_q    <= cnt_clip;
				rd_cnt_q <= 3'd0;
			end else if (ram_ctl.rd_en) begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
			end
			if (load) begin
				mix_vld_q <= 1'b1;
			end else if (mix.ready) begin
				mix_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ram_ctl.rd_addr;
		if (start) begin
			sum_q <= 10'd0;
		end else if (vld_s1) begin
			sum_q <= sum_q + {2'b00, value};
		end
		if (state_q == ST_DIV) begin
			res_q <= res_d;
		end
		if (load) begin
			sample_q <= res_q;
		end
	end

	assign cmd.ready  = cmd_rdy;
	assign mix.valid  = mix_vld_q;
	assign mix.sample = sample_q;

endmodule
